// ===== rtl/core/isam_pkg.sv =====
// Shared types and constants for the interval sort and merge block.
package isam_pkg;

   localparam int DATA_W = 32;

   // One stored interval, with its occupancy bit.
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] iv_start;
      logic signed [DATA_W-1:0] iv_end;
   } entry_type;

   // Chain control, common to every cell.
   typedef struct packed {
      logic insert;   // place the broadcast interval in sorted order
      logic shift;    // move every entry one cell toward the head
   } cell_ctrl_type;

endpackage

// ===== rtl/core/interval_sort_and_merge_top.sv =====
// Top level of the interval sort and merge block: sorting chain plus merge unit.
//
//   channel   ports                                   direction  transfer
//   request   start, busy, req_interval_start/_end,  in         start && !busy
//             req_last_interval
//   response  rsp_valid, rsp_merged_start/_end,      out        rsp_valid, one cycle
//             rsp_last_merged, rsp_overflow
//
// Each request word is sorted into the cell chain in the cycle it is accepted, so
// a set loads at one interval per cycle while no merge runs. The word marked last
// starts the merge: busy stays high while it primes the running interval from the
// head cell, takes in each further held cell as the chain shifts toward the head,
// and closes the final run once the emptied head arrives. The final word shows in
// the first idle cycle after busy falls. Results leave one per disjoint run, each
// for one cycle; the receiver cannot stall. Reset clears the occupancy bits and the
// merge state at once; interval payloads are not reset.
module interval_sort_and_merge_top
   import isam_pkg::*;
#(
   parameter int MAX_INTERVALS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_interval_start,
   input  logic signed [DATA_W-1:0] req_interval_end,
   input  logic                     req_last_interval,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_merged_start,
   output logic signed [DATA_W-1:0] rsp_merged_end,
   output logic                     rsp_last_merged,
   output logic                     rsp_overflow
);

   entry_type     cell_entry [MAX_INTERVALS];
   logic          cell_ins   [MAX_INTERVALS];
   entry_type     new_entry;
   cell_ctrl_type ctrl;
   logic          accept;
   logic          full;
   logic          shift;

   // Take a word only while no merge runs.
   assign accept = start && !busy;

   // The tail cell holds an entry only when every cell does.
   assign full = cell_entry[MAX_INTERVALS-1].valid;

   assign new_entry = '{valid: 1'b1, iv_start: req_interval_start,
                        iv_end: req_interval_end};

   // Drop the word when the chain is full; the merge shifts the chain to the head.
   assign ctrl.insert = accept && !full;
   assign ctrl.shift  = shift;

   for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
      entry_type left_entry, right_entry;
      logic      left_ins;

      if (i == 0) begin : g_head
         assign left_entry = new_entry;
         assign left_ins   = 1'b0;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_ins   = cell_ins[i-1];
      end

      if (i == MAX_INTERVALS - 1) begin : g_tail
         // empty entry enters at the tail while shifting
         assign right_entry = '{valid: 1'b0, iv_start: '0, iv_end: '0};
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      isam_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .left_ins    (left_ins),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .ins         (cell_ins[i])
      );
   end

   isam_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .accept_last  (accept && req_last_interval),
      .full         (full),
      .head         (cell_entry[0]),
      .shift        (shift),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp_start    (rsp_merged_start),
      .rsp_end      (rsp_merged_end),
      .rsp_last     (rsp_last_merged),
      .rsp_overflow (rsp_overflow)
   );

endmodule

// ===== rtl/core/isam_cell.sv =====
// One cell of the sorting chain: holds one interval and trades it with its neighbors.
module isam_cell
   import isam_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     new_entry,
   input  entry_type     left_entry,
   input  logic          left_ins,
   input  entry_type     right_entry,
   output entry_type     entry,
   output logic          ins
);

   logic                     valid_ff, valid_in;
   logic signed [DATA_W-1:0] start_ff, start_in;
   logic signed [DATA_W-1:0] end_ff, end_in;

   // The insertion point lies at or before this cell.
   assign ins = !valid_ff || (start_ff > new_entry.iv_start);

   always_comb begin
      valid_in = valid_ff;
      start_in = start_ff;
      end_in   = end_ff;
      if (ctrl.shift) begin
         valid_in = right_entry.valid;
         start_in = right_entry.iv_start;
         end_in   = right_entry.iv_end;
      end else if (ctrl.insert && ins) begin
         if (left_ins) begin
            // push down: take the neighbor's entry
            valid_in = left_entry.valid;
            start_in = left_entry.iv_start;
            end_in   = left_entry.iv_end;
         end else begin
            // this is the insertion point
            valid_in = 1'b1;
            start_in = new_entry.iv_start;
            end_in   = new_entry.iv_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
   end

   assign entry = '{valid: valid_ff, iv_start: start_ff, iv_end: end_ff};

endmodule

// ===== rtl/core/isam_merge.sv =====
// Merge unit at the head of the chain: joins overlapping intervals and emits results.
module isam_merge
   import isam_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     accept_last,
   input  logic                     full,
   input  entry_type                head,
   output logic                     shift,
   output logic                     busy,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_start,
   output logic signed [DATA_W-1:0] rsp_end,
   output logic                     rsp_last,
   output logic                     rsp_overflow
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_RUN
   } state_type;

   state_type                state_ff;
   logic                     dropped_ff;
   logic signed [DATA_W-1:0] run_start_ff, run_end_ff;
   logic                     valid_ff, last_ff, overflow_ff;
   logic signed [DATA_W-1:0] out_start_ff, out_end_ff;

   assign shift = (state_ff != ST_IDLE);
   assign busy  = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         dropped_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && full) begin
                  dropped_ff <= 1'b1;
               end
               if (accept_last) begin
                  state_ff <= ST_PRIME;
               end
            end
            ST_PRIME: begin
               run_start_ff <= head.iv_start;
               run_end_ff   <= head.iv_end;
               if (head.valid) begin
                  state_ff <= ST_RUN;
               end else begin
                  dropped_ff <= 1'b0;
                  state_ff   <= ST_IDLE;
               end
            end
            ST_RUN: begin
               if (!head.valid) begin
                  valid_ff     <= 1'b1;
                  last_ff      <= 1'b1;
                  overflow_ff  <= dropped_ff;
                  out_start_ff <= run_start_ff;
                  out_end_ff   <= run_end_ff;
                  dropped_ff   <= 1'b0;
                  state_ff     <= ST_IDLE;
               end else if (head.iv_start <= run_end_ff) begin
                  if (head.iv_end > run_end_ff) begin
                     run_end_ff <= head.iv_end;
                  end
               end else begin
                  valid_ff     <= 1'b1;
                  last_ff      <= 1'b0;
                  overflow_ff  <= dropped_ff;
                  out_start_ff <= run_start_ff;
                  out_end_ff   <= run_end_ff;
                  run_start_ff <= head.iv_start;
                  run_end_ff   <= head.iv_end;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_start    = out_start_ff;
   assign rsp_end      = out_end_ff;
   assign rsp_last     = last_ff;
   assign rsp_overflow = overflow_ff;

endmodule

// ===== rtl/core/isam_checker.sv =====
// Port-level checks for the interval sort and merge block, bound to its top level.
module isam_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last_interval,
   input logic rsp_valid,
   input logic rsp_last_merged
);

   // A non-final result leaves while the merge still runs.
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_merged |-> busy)
      else $error("non-final result shown while idle");

   // The final result coincides with the return to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_merged |-> !busy)
      else $error("final result shown while still busy");

   // A word marked last starts the merge.
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_interval |=> busy)
      else $error("merge did not start after last word");

   // Leaving the merge always delivers the final result.
   a_end_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid && rsp_last_merged)
      else $error("merge ended without final result");

endmodule

bind interval_sort_and_merge_top isam_checker u_isam_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_last_interval (req_last_interval),
   .rsp_valid         (rsp_valid),
   .rsp_last_merged   (rsp_last_merged)
);

// ===== tb/sv/isam_scoreboard_pkg.sv =====
// Scoreboard for the interval sort and merge testbench: sorting and merging predictor.
package isam_scoreboard_pkg;
   import isam_pkg::*;

   localparam int CAPACITY = 32;

   typedef struct {
      logic signed [DATA_W-1:0] m_start;
      logic signed [DATA_W-1:0] m_end;
      logic                     last_flag;
      logic                     overflow_flag;
   } merged_word_type;

   class merge_scoreboard;
      logic signed [DATA_W-1:0] sorted_start [CAPACITY];
      logic signed [DATA_W-1:0] sorted_end [CAPACITY];
      int                       held_count;
      bit                       dropped;
      merged_word_type          pending_merges [$];
      int                       error_count;
      int                       intervals_noted;
      int                       sets_closed;
      int                       overflow_sets;
      int                       words_checked;

      function new();
         held_count      = 0;
         dropped         = 1'b0;
         error_count     = 0;
         intervals_noted = 0;
         sets_closed     = 0;
         overflow_sets   = 0;
         words_checked   = 0;
      endfunction

      function int pending_count();
         return pending_merges.size();
      endfunction

      function void push_merged(input logic signed [DATA_W-1:0] m_start, m_end,
                                input logic last_flag);
         merged_word_type word;
         word.m_start       = m_start;
         word.m_end         = m_end;
         word.last_flag     = last_flag;
         word.overflow_flag = dropped;
         pending_merges.push_back(word);
      endfunction

      // Insert one accepted word in start order; on the last word merge the set.
      function void note_interval(input logic signed [DATA_W-1:0] iv_start, iv_end,
                                  input logic last_flag);
         int                       pos;
         logic signed [DATA_W-1:0] run_start;
         logic signed [DATA_W-1:0] run_end;
         intervals_noted++;
         if (held_count < CAPACITY) begin
            pos = held_count;
            // strict compare keeps equal starts in arrival order
            while (pos > 0 && sorted_start[pos-1] > iv_start) begin
               sorted_start[pos] = sorted_start[pos-1];
               sorted_end[pos]   = sorted_end[pos-1];
               pos--;
            end
            sorted_start[pos] = iv_start;
            sorted_end[pos]   = iv_end;
            held_count++;
         end else begin
            dropped = 1'b1;
         end
         if (!last_flag) return;
         if (held_count > 0) begin
            run_start = sorted_start[0];
            run_end   = sorted_end[0];
            for (int i = 1; i < held_count; i++) begin
               if (sorted_start[i] <= run_end) begin
                  if (sorted_end[i] > run_end) run_end = sorted_end[i];
               end else begin
                  push_merged(run_start, run_end, 1'b0);
                  run_start = sorted_start[i];
                  run_end   = sorted_end[i];
               end
            end
            push_merged(run_start, run_end, 1'b1);
         end
         sets_closed++;
         if (dropped) overflow_sets++;
         held_count = 0;
         dropped    = 1'b0;
      endfunction

      task report_mismatch(input string what);
         error_count++;
         $display("MISMATCH: %s", what);
      endtask

      task check_merged(input logic signed [DATA_W-1:0] m_start, m_end,
                        input logic last_flag, overflow_flag);
         merged_word_type want;
         if (pending_merges.size() == 0) begin
            report_mismatch($sformatf("merged word [%0d, %0d] arrived with none expected",
                                      m_start, m_end));
            return;
         end
         want = pending_merges.pop_front();
         words_checked++;
         if (m_start !== want.m_start)
            report_mismatch($sformatf("merged_start %0d, expected %0d", m_start, want.m_start));
         if (m_end !== want.m_end)
            report_mismatch($sformatf("merged_end %0d, expected %0d", m_end, want.m_end));
         if (last_flag !== want.last_flag)
            report_mismatch($sformatf("last_merged %b, expected %b", last_flag,
                                      want.last_flag));
         if (overflow_flag !== want.overflow_flag)
            report_mismatch($sformatf("overflow %b, expected %b", overflow_flag,
                                      want.overflow_flag));
      endtask
   endclass

endpackage

// ===== tb/sv/testbench.sv =====
// Top-level testbench for the interval sort and merge block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import isam_pkg::*;
   import isam_scoreboard_pkg::*;

   // Quiet cycles allowed before the run is declared hung. The longest correct
   // quiet stretch is a merge of a full set into a single word plus a rare long
   // sender gap; this leaves a wide margin.
   localparam int QUIET_LIMIT = 2000;

   localparam logic signed [DATA_W-1:0] MIN_POINT = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] MAX_POINT = {1'b0, {(DATA_W-1){1'b1}}};

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic signed [DATA_W-1:0] req_interval_start = '0;
   logic signed [DATA_W-1:0] req_interval_end = '0;
   logic                     req_last_interval = 1'b0;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_merged_start;
   logic signed [DATA_W-1:0] rsp_merged_end;
   logic                     rsp_last_merged;
   logic                     rsp_overflow;

   merge_scoreboard merge_board = new();

   int idle_pct = 0;      // chance, in percent, that the sender idles a given cycle
   int items_sent = 0;    // random words sent so far
   int quiet_cycles = 0;

   interval_sort_and_merge_top #(
      .MAX_INTERVALS(CAPACITY)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_interval_start (req_interval_start),
      .req_interval_end   (req_interval_end),
      .req_last_interval  (req_last_interval),
      .rsp_valid          (rsp_valid),
      .rsp_merged_start   (rsp_merged_start),
      .rsp_merged_end     (rsp_merged_end),
      .rsp_last_merged    (rsp_last_merged),
      .rsp_overflow       (rsp_overflow)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // A word moves at the rising edge where start is high and busy is low.
   wire word_accepted = !reset && start && (busy === 1'b0);

   // Sample at the rising edge: check results first, then note the accepted word,
   // so a closing word never disturbs the words already waiting.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1)
            merge_board.check_merged(rsp_merged_start, rsp_merged_end,
                                     rsp_last_merged, rsp_overflow);
         if (word_accepted)
            merge_board.note_interval(req_interval_start, req_interval_end,
                                      req_last_interval);
      end
   end

   // Watchdog: end the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if (word_accepted || rsp_valid === 1'b1) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= QUIET_LIMIT) begin
               $display("TEST FAILED");
               $finish;
            end
         end
      end
   end

   // Present one word at the falling edge and hold it until accepted. Start stays
   // high on return; whatever follows must begin at the next falling edge.
   task automatic send_interval(input logic signed [DATA_W-1:0] iv_start, iv_end,
                                input logic last_flag);
      @(negedge clock);
      start              = 1'b1;
      req_interval_start = iv_start;
      req_interval_end   = iv_end;
      req_last_interval  = last_flag;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Idle the sender for a random number of cycles; drive noise on the fields.
   task automatic idle_gap();
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start              = 1'b0;
         req_interval_start = $urandom;
         req_interval_end   = $urandom;
         req_last_interval  = 1'($urandom_range(1));
      end
   endtask

   // Drop start and hold off until every expected word is back, then let any
   // merge still in flight settle.
   task automatic wait_for_drain();
      @(negedge clock);
      start = 1'b0;
      while (merge_board.pending_count() != 0) @(posedge clock);
      repeat (CAPACITY + 4) @(posedge clock);
   endtask

   // Pick one point: a narrow band around zero for dense overlaps, the full range,
   // or a corner point: an extreme of the signed range, its neighbour, -1 or 0.
   function automatic logic signed [DATA_W-1:0] random_point(input int style);
      case (style)
         0: begin
            return $signed(DATA_W'($urandom_range(200))) - 100;
         end
         1: begin
            return $urandom;
         end
         default: begin
            case ($urandom_range(5))
               0: return MIN_POINT;
               1: return MAX_POINT;
               2: return MIN_POINT + 1;
               3: return MAX_POINT - 1;
               4: return -1;
               default: return 0;
            endcase
         end
      endcase
   endfunction

   // Send one well-formed set of set_size words; the last word closes it.
   task automatic send_random_set(input int set_size);
      int                       style;
      int                       pick;
      logic signed [DATA_W-1:0] iv_start;
      logic signed [DATA_W-1:0] iv_end;
      logic signed [DATA_W-1:0] span;
      pick  = $urandom_range(99);
      style = (pick < 60) ? 0 : (pick < 85) ? 1 : 2;
      for (int k = 0; k < set_size; k++) begin
         idle_gap();
         iv_start = random_point(style);
         span     = $urandom_range(30);
         pick     = $urandom_range(99);
         if (pick < 70)      iv_end = iv_start + span;
         else if (pick < 85) iv_end = iv_start - span;  // reversed interval
         else                iv_end = random_point(style);
         send_interval(iv_start, iv_end, k == set_size - 1);
         items_sent++;
      end
   endtask

   initial begin
      int pick;
      int set_size;

      // Hold reset, then release it at a falling edge.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: single extreme intervals, one forward and one reversed.
      send_interval(MIN_POINT, MAX_POINT, 1'b1);
      send_interval(MAX_POINT, MIN_POINT, 1'b1);
      // Single points at the extremes and around zero, each its own disjoint run.
      send_interval(MAX_POINT, MAX_POINT, 1'b0);
      send_interval(MIN_POINT, MIN_POINT, 1'b0);
      send_interval(0, 0, 1'b0);
      send_interval(-1, -1, 1'b1);
      // Touching, reversed, equal starts in both arrival orders, out of order input.
      send_interval(20, 30, 1'b0);
      send_interval(10, 20, 1'b0);
      send_interval(-5, -1, 1'b0);
      send_interval(40, 35, 1'b0);
      send_interval(40, 60, 1'b0);
      send_interval(41, 45, 1'b0);
      send_interval(70, 80, 1'b0);
      send_interval(70, 75, 1'b0);
      send_interval(65, 66, 1'b1);
      // Everything nests into one merged word.
      send_interval(0, 100, 1'b0);
      send_interval(5, 6, 1'b0);
      send_interval(50, 200, 1'b0);
      send_interval(-10, 0, 1'b1);
      wait_for_drain();

      // Random: a set that just fills the store, one whose closing word is dropped,
      // then three phases of mixed set sizes at idle chances of 30, 60 and 0 percent.
      idle_pct = 30;
      send_random_set(CAPACITY);
      send_random_set(CAPACITY + 1);
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 30 : (phase == 1) ? 60 : 0;
         while (items_sent < (phase + 1) * 150) begin
            pick = $urandom_range(99);
            if (pick < 70)      set_size = $urandom_range(1, 8);
            else if (pick < 92) set_size = $urandom_range(9, CAPACITY);
            else                set_size = $urandom_range(CAPACITY + 1, CAPACITY + 8);
            send_random_set(set_size);
            // Now and then hold off until the block has emptied.
            if ($urandom_range(19) == 0) wait_for_drain();
         end
         wait_for_drain();
      end

      if (merge_board.pending_count() != 0)
         merge_board.report_mismatch($sformatf("%0d merged words never arrived",
                                               merge_board.pending_count()));
      $display("Run covered %0d intervals in %0d sets (%0d with dropped intervals),",
               merge_board.intervals_noted, merge_board.sets_closed,
               merge_board.overflow_sets);
      $display("%0d merged words checked, %0d mismatches.",
               merge_board.words_checked, merge_board.error_count);
      if (merge_board.error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== interval_sort_and_merge_top.f =====
rtl/core/isam_pkg.sv
rtl/core/isam_cell.sv
rtl/core/isam_merge.sv
rtl/core/interval_sort_and_merge_top.sv
rtl/core/isam_checker.sv
tb/sv/isam_scoreboard_pkg.sv
tb/sv/testbench.sv
